// ===== rtl/lcl_pkg.sv =====
// ----------------------------------------------------------------------------
// lcl_pkg
// Shared sizes, command codes and word types for the LCS length table.
// ----------------------------------------------------------------------------
package lcl_pkg;

	localparam int MAX_LEN  = 64;
	localparam int SYM_BITS = 16;

	localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W  = $clog2(MAX_LEN + 1);
	localparam int ROW_AW = $clog2(MAX_LEN + 1);

	localparam int SYMBOL_W = 16;
	localparam int LEN_W    = 7;

	typedef enum logic [1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [SYMBOL_W-1:0] symbol;
	} in_word_t;

	typedef struct packed {
		logic [LEN_W-1:0] lcs_length;
		logic             dropped;
	} out_word_t;

	// Read requests from the table engine to the sequence stores.
	typedef struct packed {
		logic             a_en;
		logic [IDX_W-1:0] a_addr;
		logic             b_en;
		logic [IDX_W-1:0] b_addr;
	} seq_rd_t;

	// Engine status towards the top level.
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] len;
	} eng_status_t;

endpackage

// ===== rtl/lcl_seq_store.sv =====
// ----------------------------------------------------------------------------
// lcl_seq_store
// Holds sequences A and B in two synchronous memories together with their
// element counts and the overflow flag.
// ----------------------------------------------------------------------------
module lcl_seq_store import lcl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_accept,
	input  in_word_t            wr_word,
	input  seq_rd_t             rd,
	output logic [SYM_BITS-1:0] a_data,
	output logic [SYM_BITS-1:0] b_data,
	output logic [CNT_W-1:0]    count_a,
	output logic [CNT_W-1:0]    count_b,
	output logic                overflow
);

	logic [SYM_BITS-1:0] mem_a [0:MAX_LEN-1];
	logic [SYM_BITS-1:0] mem_b [0:MAX_LEN-1];
	logic [SYM_BITS-1:0] a_data_q, b_data_q;
	logic [CNT_W-1:0]    count_a_q, count_b_q;
	logic                overflow_q;
	logic [SYM_BITS-1:0] sym;
	logic                full_a, full_b;

	assign sym    = wr_word.symbol[SYM_BITS-1:0];
	assign full_a = (count_a_q == CNT_W'(MAX_LEN));
	assign full_b = (count_b_q == CNT_W'(MAX_LEN));

	always_ff @(posedge clk) begin
		if (wr_accept && wr_word.cmd == CMD_LOAD_A && !full_a) begin
			mem_a[count_a_q[IDX_W-1:0]] <= sym;
		end
		if (wr_accept && wr_word.cmd == CMD_LOAD_B && !full_b) begin
			mem_b[count_b_q[IDX_W-1:0]] <= sym;
		end
		if (rd.a_en) begin
			a_data_q <= mem_a[rd.a_addr];
		end
		if (rd.b_en) begin
			b_data_q <= mem_b[rd.b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q  <= '0;
			count_b_q  <= '0;
			overflow_q <= 1'b0;
		end else if (wr_accept) begin
			case (wr_word.cmd)
				CMD_LOAD_A: begin
					if (full_a) overflow_q <= 1'b1;
					else        count_a_q  <= count_a_q + 1'b1;
				end
				CMD_LOAD_B: begin
					if (full_b) overflow_q <= 1'b1;
					else        count_b_q  <= count_b_q + 1'b1;
				end
				CMD_CLEAR: begin
					count_a_q  <= '0;
					count_b_q  <= '0;
					overflow_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign a_data   = a_data_q;
	assign b_data   = b_data_q;
	assign count_a  = count_a_q;
	assign count_b  = count_b_q;
	assign overflow = overflow_q;

endmodule

// ===== rtl/lcl_dp_engine.sv =====
// ----------------------------------------------------------------------------
// lcl_dp_engine
// Walks the LCS table one cell per cycle within each row over a single row memory,
// reading the previous row's value and writing the new one back behind it.
// ----------------------------------------------------------------------------
module lcl_dp_engine import lcl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CNT_W-1:0]    count_a,
	input  logic [CNT_W-1:0]    count_b,
	input  logic [SYM_BITS-1:0] a_data,
	input  logic [SYM_BITS-1:0] b_data,
	input  logic                take,
	output seq_rd_t             rd,
	output eng_status_t         status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_CELL,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] n_q, m_q, i_q, j_q, len_q;
	logic [CNT_W-1:0] left_q, diag_q;

	logic [CNT_W-1:0] row_mem [0:MAX_LEN];
	logic [CNT_W-1:0] row_rd_q;

	logic             v_s1, first_col_s1, first_row_s1, last_s1;
	logic [CNT_W-1:0] j_s1;

	logic             last_col, last_row;
	logic [CNT_W-1:0] up, left, diag, cell_new;

	assign last_col = (j_q == m_q);
	assign last_row = (i_q == CNT_W'(n_q - 1'b1));

	always_comb begin
		rd.a_en   = (state_q == ST_ROW);
		rd.a_addr = i_q[IDX_W-1:0];
		rd.b_en   = (state_q == ST_CELL);
		rd.b_addr = IDX_W'(j_q - 1'b1);
	end

	// The first row sees a cleared row above it, and column zero is zero.
	always_comb begin
		up   = first_row_s1 ? '0 : row_rd_q;
		left = first_col_s1 ? '0 : left_q;
		diag = first_col_s1 ? '0 : diag_q;
		if (a_data == b_data) cell_new = diag + 1'b1;
		else if (left >= up)  cell_new = left;
		else                  cell_new = up;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CELL) begin
			row_rd_q <= row_mem[ROW_AW'(j_q)];
		end
		if (v_s1) begin
			row_mem[ROW_AW'(j_s1)] <= cell_new;
			left_q <= cell_new;
			diag_q <= up;
		end
		j_s1         <= j_q;
		first_col_s1 <= (j_q == CNT_W'(1));
		first_row_s1 <= (i_q == '0);
		last_s1      <= last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
			n_q     <= '0;
			m_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			len_q   <= '0;
		end else begin
			v_s1 <= (state_q == ST_CELL);
			if (v_s1 && last_s1) begin
				len_q <= cell_new;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q <= count_a;
						m_q <= count_b;
						i_q <= '0;
						if (count_a == '0 || count_b == '0) begin
							len_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_ROW;
						end
					end
				end
				ST_ROW: begin
					// This cycle also lets the last write of the row land before
					// the next row reads the same entry.
					j_q     <= CNT_W'(1);
					state_q <= ST_CELL;
				end
				ST_CELL: begin
					if (last_col) begin
						i_q     <= i_q + 1'b1;
						state_q <= last_row ? ST_DRAIN : ST_ROW;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (take) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status.busy = (state_q != ST_IDLE);
	assign status.done = (state_q == ST_FIN);
	assign status.len  = len_q;

endmodule

// ===== rtl/lcs_length_table.sv =====
// ----------------------------------------------------------------------------
// lcs_length_table
// Loads two symbol sequences and returns the length of their longest common
// subsequence, computed over a single row of the table.
//
//   channel  direction  word        handshake
//   item     in         in_word_t   item_valid / item_stall
//   result   out        out_word_t  result_valid / result_stall
//
// Load and clear words may arrive every cycle while item_stall is low.
// A compute reads one element of sequence A per row and then walks that row of
// the row memory one cell per cycle; with an empty sequence it skips the walk
// and returns length zero.
// Reset clears the counts, the overflow flag and all control state; the
// stores need no clearing. item_stall is high for the whole compute until its
// result has moved into the output register, which holds while result_stall.
// ----------------------------------------------------------------------------
module lcs_length_table import lcl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_word_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	logic                accept;
	logic                start;
	logic                take;
	seq_rd_t             rd;
	eng_status_t         status;
	logic [SYM_BITS-1:0] a_data, b_data;
	logic [CNT_W-1:0]    count_a, count_b;
	logic                overflow;
	logic                result_valid_q;
	out_word_t           result_q;

	assign item_stall = status.busy;
	assign accept     = item_valid && !item_stall;
	assign start      = accept && item.cmd == CMD_COMPUTE;
	assign take       = status.done && (!result_valid_q || !result_stall);

	lcl_seq_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_accept (accept),
		.wr_word   (item),
		.rd        (rd),
		.a_data    (a_data),
		.b_data    (b_data),
		.count_a   (count_a),
		.count_b   (count_b),
		.overflow  (overflow)
	);

	lcl_dp_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.count_a (count_a),
		.count_b (count_b),
		.a_data  (a_data),
		.b_data  (b_data),
		.take    (take),
		.rd      (rd),
		.status  (status)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			result_q.lcs_length <= LEN_W'(status.len);
			result_q.dropped    <= overflow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
